// ===== design/tnts_pkg.sv =====
// Package for the text normalize and tokenize stream unit.
// Holds the item descriptor type, character codes and the digit word table.
// Depends on nothing.
package tnts_pkg;

    // Class of a normalized input character.
    typedef enum logic [1:0] {
        CLS_DROP,
        CLS_CHAR,
        CLS_SEP,
        CLS_WORD
    } t_cls;

    // One classified input character. For CLS_WORD the low four bits of
    // data hold the digit value, otherwise data is the lower-cased byte.
    typedef struct packed {
        t_cls       cls;
        logic [7:0] data;
        logic       last;
    } t_desc;

    localparam int   WORD_MAX = 6;
    localparam int   POS_W    = 3;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_DELTA = 8'h20;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_EXCL    = 8'h21;
    localparam logic [7:0] CH_QUEST   = 8'h3F;

    localparam int WORD_BITS = 8 * WORD_MAX;

    // French word of a digit, first letter in the top byte.
    function automatic logic [WORD_BITS-1:0] digit_word(input logic [3:0] d);
        logic [WORD_BITS-1:0] w;
        unique case (d)
            4'd0:    w = {"zero",   16'h0};
            4'd1:    w = {"un",     32'h0};
            4'd2:    w = {"deux",   16'h0};
            4'd3:    w = {"trois",   8'h0};
            4'd4:    w = {"quatre"};
            4'd5:    w = {"cinq",   16'h0};
            4'd6:    w = {"six",    24'h0};
            4'd7:    w = {"sept",   16'h0};
            4'd8:    w = {"huit",   16'h0};
            4'd9:    w = {"neuf",   16'h0};
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [POS_W-1:0] digit_len(input logic [3:0] d);
        logic [POS_W-1:0] n;
        unique case (d)
            4'd0:    n = 3'd4;
            4'd1:    n = 3'd2;
            4'd2:    n = 3'd4;
            4'd3:    n = 3'd5;
            4'd4:    n = 3'd6;
            4'd5:    n = 3'd4;
            4'd6:    n = 3'd3;
            4'd7:    n = 3'd4;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Letter at position p of the word for digit d.
    function automatic logic [7:0] digit_letter(input logic [3:0] d,
                                                input logic [POS_W-1:0] p);
        logic [WORD_BITS-1:0] w;
        logic [POS_W-1:0]     back;
        w    = digit_word(d);
        back = POS_W'(WORD_MAX - 1) - p;
        w    = w >> {back, 3'b000};
        return w[7:0];
    endfunction

endpackage

// ===== design/tnts_front.sv =====
// Front end of the text normalize and tokenize stream unit.
// Lower-cases and classifies each input beat. Uses tnts_pkg.
module tnts_front (
    input  logic          i_tvalid,
    output logic          o_tready,
    input  logic [7:0]    i_tdata,
    input  logic          i_tlast,
    input  logic          i_full,
    output logic          o_push,
    output tnts_pkg::t_desc o_desc
);

    logic [7:0]     lc;
    tnts_pkg::t_cls cls;
    logic [7:0]     diff;

    always_comb begin
        if (i_tdata >= tnts_pkg::CH_UPPER_A && i_tdata <= tnts_pkg::CH_UPPER_Z) begin
            lc = i_tdata + tnts_pkg::CASE_DELTA;
        end else begin
            lc = i_tdata;
        end
        diff = lc - tnts_pkg::CH_DIGIT_0;
        if (lc >= tnts_pkg::CH_DIGIT_0 && lc <= tnts_pkg::CH_DIGIT_9) begin
            cls = tnts_pkg::CLS_WORD;
        end else begin
            unique case (lc)
                tnts_pkg::CH_DOT, tnts_pkg::CH_COMMA, tnts_pkg::CH_SEMI,
                tnts_pkg::CH_COLON, tnts_pkg::CH_EXCL, tnts_pkg::CH_QUEST:
                    cls = tnts_pkg::CLS_DROP;
                tnts_pkg::CH_SPACE, tnts_pkg::CH_APOS:
                    cls = tnts_pkg::CLS_SEP;
                default:
                    cls = tnts_pkg::CLS_CHAR;
            endcase
        end
    end

    always_comb begin
        o_desc.cls  = cls;
        o_desc.data = (cls == tnts_pkg::CLS_WORD) ? {4'b0, diff[3:0]} : lc;
        o_desc.last = i_tlast;
    end

    // A dropped mark that does not close a sentence yields nothing.
    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full && !(cls == tnts_pkg::CLS_DROP && !i_tlast);

endmodule

// ===== design/tnts_queue.sv =====
// Two-entry descriptor queue between front and back end.
// Uses tnts_pkg for the descriptor type.
module tnts_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tnts_pkg::t_desc i_desc,
    output logic            o_full,
    output logic            o_valid,
    output tnts_pkg::t_desc o_head,
    input  logic            i_pop
);

    tnts_pkg::t_desc r_mem [2];
    logic            r_wr_ptr, n_wr_ptr;
    logic            r_rd_ptr, n_rd_ptr;
    logic [1:0]      r_count,  n_count;

    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_head  = r_mem[r_rd_ptr];

endmodule

// ===== design/tnts_back.sv =====
// Back end of the text normalize and tokenize stream unit.
// Expands one descriptor into its result beats. Uses tnts_pkg.
module tnts_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  tnts_pkg::t_desc     i_head,
    output logic                o_pop,
    output logic                o_tvalid,
    input  logic                i_tready,
    output logic [7:0]          o_tdata,
    output logic [1:0]          o_tuser,
    output logic                o_tlast
);

    logic [tnts_pkg::POS_W-1:0] r_pos, n_pos;
    logic                       r_tvalid;
    logic [7:0]                 r_tdata;
    logic [1:0]                 r_tuser;
    logic                       r_tlast;

    logic [tnts_pkg::POS_W-1:0] main_len;
    logic [tnts_pkg::POS_W-1:0] total;
    logic                       advance;
    logic                       fire;
    logic                       final_beat;
    logic                       res_kind;
    logic [7:0]                 res_ch;
    logic                       res_done;

    always_comb begin
        case (i_head.cls)
            tnts_pkg::CLS_DROP: main_len = '0;
            tnts_pkg::CLS_WORD: main_len = tnts_pkg::digit_len(i_head.data[3:0]);
            default:            main_len = tnts_pkg::POS_W'(1);
        endcase
        total      = main_len + tnts_pkg::POS_W'(i_head.last);
        advance    = !r_tvalid || i_tready;
        fire       = advance && i_valid;
        final_beat = r_pos == total - tnts_pkg::POS_W'(1);

        if (r_pos < main_len) begin
            res_done = 1'b0;
            case (i_head.cls)
                tnts_pkg::CLS_SEP: begin
                    res_kind = tnts_pkg::KIND_END;
                    res_ch   = 8'h00;
                end
                tnts_pkg::CLS_WORD: begin
                    res_kind = tnts_pkg::KIND_CHAR;
                    res_ch   = tnts_pkg::digit_letter(i_head.data[3:0], r_pos);
                end
                default: begin
                    res_kind = tnts_pkg::KIND_CHAR;
                    res_ch   = i_head.data;
                end
            endcase
        end else begin
            // Closing marker of the sentence.
            res_kind = tnts_pkg::KIND_END;
            res_ch   = 8'h00;
            res_done = 1'b1;
        end

        if (fire) begin
            n_pos = final_beat ? '0 : r_pos + tnts_pkg::POS_W'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_tvalid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (advance) begin
                r_tvalid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_tdata <= res_ch;
            r_tuser <= {res_done, res_kind};
            r_tlast <= final_beat;
        end
    end

    assign o_pop    = fire && final_beat;
    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;

endmodule

// ===== design/text_normalize_tokenize_stream_unit.sv =====
// Text normalize and tokenize stream unit: top level.
// An accepted input beat passes through the queue and then the registered
// output stage. Output: one result beat per cycle while the output is ready
// and a descriptor waits; an input beat causes up to seven result beats, set
// by the result expander; the queue takes new input beats while not full.
// Reset (synchronous, active low) empties the queue and the output register.
// Depends on tnts_pkg, tnts_front, tnts_queue and tnts_back.
module text_normalize_tokenize_stream_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input stream: one sentence character per beat.
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] ch
    input  logic       i_s_tlast,   // sentence_end
    // Output stream: one token character or end-of-token marker per beat.
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] ch_out
    output logic [1:0] o_m_tuser,   // [0] kind, [1] sentence_done
    output logic       o_m_tlast    // run_last
);

    // The front end lower-cases and classifies every beat at the input and
    // pushes a descriptor; dropped punctuation that does not end a sentence
    // never enters the queue, so it causes no result beat.
    logic            push;
    logic            full;
    tnts_pkg::t_desc front_desc;

    tnts_front u_front (
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_tdata  (i_s_tdata),
        .i_tlast  (i_s_tlast),
        .i_full   (full),
        .o_push   (push),
        .o_desc   (front_desc)
    );

    // A two-entry queue lets the input keep flowing while the back end
    // spells out a digit word or waits on the output.
    logic            head_valid;
    tnts_pkg::t_desc head;
    logic            pop;

    tnts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (front_desc),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head),
        .i_pop   (pop)
    );

    // The back end walks each descriptor one result beat at a time into a
    // registered output stage; run_last marks the last beat of a descriptor.
    tnts_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (head_valid),
        .i_head   (head),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser),
        .o_tlast  (o_m_tlast)
    );

endmodule
